@@ rtl/core/cau_pkg.sv @@
`timescale 1ns / 1ps

package cau_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Number of cells in each divider and root chain: one result bit per cell.
  localparam int STEPS = 32;

  localparam int TOL_W = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_SCALE = 4'd4;
  localparam logic [3:0] OP_RDIV  = 4'd5;
  localparam logic [3:0] OP_CONJ  = 4'd6;
  localparam logic [3:0] OP_NEG   = 4'd7;
  localparam logic [3:0] OP_MAG   = 4'd8;
  localparam logic [3:0] OP_SQRT  = 4'd9;
  localparam logic [3:0] OP_EQ    = 4'd10;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_re;
    logic signed [31:0] result_im;
    logic               is_equal;
    logic               divide_by_zero;
    logic               saturated;
  } out_t;

endpackage

@@ rtl/core/complex_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// Every operation takes the same path from the start beat to the done strobe.
// Throughput: one beat per cycle; busy is never raised, and the receiver cannot stall.
// The depth is set by two 32-cell root chains in series (magnitude, then the half roots).
// Reset clears the valid pipeline and loads the tolerance register with 66.
// The result is held on the result ports for the single cycle in which done is high.

module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  cau_pkg::in_t             item,
  output logic                     done,
  output cau_pkg::out_t            result,
  input  logic                     tol_write,
  input  logic [cau_pkg::TOL_W-1:0] tol_data
);

  import cau_pkg::*;

  // Shift that turns the Q-format dividend into a 32-bit quotient problem.
  localparam int SH  = 32 - FRAC_BITS;
  // Input, products, operand prep, divider setup, chain, formatting, chain, output.
  localparam int LAT = 2 * STEPS + 6;

  // Sideband that travels beside the chains: finished results of the
  // simple operations and everything needed to finish the others.
  typedef struct packed {
    logic [3:0]         op;
    logic [31:0]        re;
    logic [31:0]        im;
    logic               eq;
    logic               dz;
    logic               sat;
    logic signed [31:0] ar;
    logic               ai_neg;
    logic               neg_re;
    logic               neg_im;
    logic               nz_re;
    logic               nz_im;
    logic               big_re;
    logic               big_im;
    logic               dzero;
  } side_t;

  // Clip a wide signed value to 32 bits; the top bit flags clipping.
  function automatic logic [32:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) begin
      return {1'b1, Q_MAX};
    end else if (v < -65'sd2147483648) begin
      return {1'b1, Q_MIN};
    end
    return {1'b0, v[31:0]};
  endfunction

  // Turn an unsigned quotient and remainder flag into the floored signed result.
  function automatic logic [32:0] div_fmt(input logic neg, input logic big,
                                          input logic dzero, input logic nz,
                                          input logic [31:0] q, input logic rnz);
    logic [32:0] c;
    logic [32:0] nc;
    c  = {1'b0, q} + {32'd0, rnz};
    nc = ~c + 33'd1;
    if (dzero) begin
      if (!nz) begin
        return '0;
      end
      return {1'b1, neg ? Q_MIN : Q_MAX};
    end
    if (big) begin
      return {1'b1, neg ? Q_MIN : Q_MAX};
    end
    if (!neg) begin
      return q[31] ? {1'b1, Q_MAX} : {1'b0, q};
    end
    if (c > {2'b01, 31'd0}) begin
      return {1'b1, Q_MIN};
    end
    return {1'b0, nc[31:0]};
  endfunction

  // The pipeline never refuses a beat.
  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  logic [TOL_W-1:0] tolerance;
  logic [LAT-1:0]   vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
      vld       <= '0;
    end else begin
      if (tol_write) begin
        tolerance <= tol_data;
      end
      vld <= {vld[LAT-2:0], accept};
    end
  end

  assign done = vld[LAT-1];

  // Stage 0: capture the beat.
  in_t in0;
  always_ff @(posedge clk) begin
    in0 <= item;
  end

  // Stage 1: six 32x32 products. The two square terms feed either the
  // divisor of a complex divide or the squared magnitude.
  in_t                in1;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir, p_sa, p_sb;
  logic signed [31:0] sq_a, sq_b;
  logic               use_a;

  assign use_a = (in0.operation == OP_MAG) || (in0.operation == OP_SQRT);
  assign sq_a  = use_a ? in0.a_re : in0.b_re;
  assign sq_b  = use_a ? in0.a_im : in0.b_im;

  always_ff @(posedge clk) begin
    in1  <= in0;
    p_rr <= $signed(in0.a_re) * $signed(in0.b_re);
    p_ii <= $signed(in0.a_im) * $signed(in0.b_im);
    p_ri <= $signed(in0.a_re) * $signed(in0.b_im);
    p_ir <= $signed(in0.a_im) * $signed(in0.b_re);
    p_sa <= sq_a * sq_a;
    p_sb <= sq_b * sq_b;
  end

  // Stage 2: finish the simple operations and prepare the divider and
  // root operands. All sums are kept exact in 65 bits.
  logic signed [64:0] xar, xai, xbr, xbi;
  logic signed [64:0] xrr, xii, xri, xir;
  logic signed [64:0] mul_re, mul_im, ds_re, ds_im;
  logic signed [32:0] dif_re, dif_im;
  logic [32:0]        adif_re, adif_im;
  logic [32:0]        abs_ar, abs_ai, abs_br;
  logic [63:0]        sq_sum;

  assign xar = {{33{in1.a_re[31]}}, in1.a_re};
  assign xai = {{33{in1.a_im[31]}}, in1.a_im};
  assign xbr = {{33{in1.b_re[31]}}, in1.b_re};
  assign xbi = {{33{in1.b_im[31]}}, in1.b_im};
  assign xrr = {p_rr[63], p_rr};
  assign xii = {p_ii[63], p_ii};
  assign xri = {p_ri[63], p_ri};
  assign xir = {p_ir[63], p_ir};

  assign mul_re  = xrr - xii;
  assign mul_im  = xri + xir;
  assign ds_re   = xrr + xii;
  assign ds_im   = xir - xri;
  assign dif_re  = xar[32:0] - xbr[32:0];
  assign dif_im  = xai[32:0] - xbi[32:0];
  assign adif_re = dif_re[32] ? 33'(-dif_re) : 33'(dif_re);
  assign adif_im = dif_im[32] ? 33'(-dif_im) : 33'(dif_im);
  assign abs_ar  = xar[32] ? 33'(-xar[32:0]) : xar[32:0];
  assign abs_ai  = xai[32] ? 33'(-xai[32:0]) : xai[32:0];
  assign abs_br  = xbr[32] ? 33'(-xbr[32:0]) : xbr[32:0];
  assign sq_sum  = $unsigned(p_sa) + $unsigned(p_sb);

  side_t       side2, side2_next;
  logic [63:0] n_re2, n_im2, dv2, x2;
  logic [63:0] n_re2_next, n_im2_next, dv2_next;
  logic [32:0] lo_re, lo_im;
  logic [64:0] mag_re, mag_im;

  assign mag_re = ds_re[64] ? 65'(-ds_re) : 65'(ds_re);
  assign mag_im = ds_im[64] ? 65'(-ds_im) : 65'(ds_im);

  always_comb begin
    side2_next        = '0;
    side2_next.op     = in1.operation;
    side2_next.ar     = in1.a_re;
    side2_next.ai_neg = in1.a_im[31];
    lo_re             = '0;
    lo_im             = '0;
    n_re2_next        = '0;
    n_im2_next        = '0;
    dv2_next          = '0;
    case (in1.operation)
      OP_ADD: begin
        lo_re = sat32(xar + xbr);
        lo_im = sat32(xai + xbi);
      end
      OP_SUB: begin
        lo_re = sat32(xar - xbr);
        lo_im = sat32(xai - xbi);
      end
      OP_MUL: begin
        lo_re = sat32(mul_re >>> FRAC_BITS);
        lo_im = sat32(mul_im >>> FRAC_BITS);
      end
      OP_SCALE: begin
        lo_re = sat32(xrr >>> FRAC_BITS);
        lo_im = sat32(xir >>> FRAC_BITS);
      end
      OP_CONJ: begin
        lo_re = {1'b0, in1.a_re};
        lo_im = sat32(-xai);
      end
      OP_NEG: begin
        lo_re = sat32(-xar);
        lo_im = sat32(-xai);
      end
      OP_EQ: begin
        side2_next.eq = (adif_re <= {2'b00, tolerance}) &&
                        (adif_im <= {2'b00, tolerance});
      end
      OP_DIV: begin
        n_re2_next        = mag_re[63:0];
        n_im2_next        = mag_im[63:0];
        dv2_next          = sq_sum;
        side2_next.neg_re = ds_re[64];
        side2_next.neg_im = ds_im[64];
      end
      OP_RDIV: begin
        n_re2_next        = {31'd0, abs_ar};
        n_im2_next        = {31'd0, abs_ai};
        dv2_next          = {31'd0, abs_br};
        side2_next.neg_re = in1.a_re[31] ^ in1.b_re[31];
        side2_next.neg_im = in1.a_im[31] ^ in1.b_re[31];
      end
      default: begin
      end
    endcase
    side2_next.re  = lo_re[31:0];
    side2_next.im  = lo_im[31:0];
    side2_next.sat = lo_re[32] | lo_im[32];
  end

  always_ff @(posedge clk) begin
    side2 <= side2_next;
    n_re2 <= n_re2_next;
    n_im2 <= n_im2_next;
    dv2   <= dv2_next;
    x2    <= sq_sum;
  end

  // Stage 3: divider setup. A quotient of 2^32 or more is caught by one
  // compare, so the chains only need 32 quotient bits; the starting
  // remainder is then below the divisor.
  logic [95:0] d_wide;
  side_t       side3, side3_next;
  logic [63:0] r0_re, r0_im, dv3, x3;
  logic [31:0] bits_re, bits_im;

  assign d_wide = {32'd0, dv2} << SH;

  always_comb begin
    side3_next        = side2;
    side3_next.big_re = ({32'd0, n_re2} >= d_wide);
    side3_next.big_im = ({32'd0, n_im2} >= d_wide);
    side3_next.nz_re  = (n_re2 != '0);
    side3_next.nz_im  = (n_im2 != '0);
    side3_next.dzero  = (dv2 == '0);
  end

  always_ff @(posedge clk) begin
    side3   <= side3_next;
    r0_re   <= n_re2 >> SH;
    r0_im   <= n_im2 >> SH;
    bits_re <= n_re2[31:0] << FRAC_BITS;
    bits_im <= n_im2[31:0] << FRAC_BITS;
    dv3     <= dv2;
    x3      <= x2;
  end

  // First chain section: both quotient lanes and the magnitude root.
  logic [31:0] q_re, q_im, m;
  logic        rnz_re, rnz_im;

  cau_div_chain u_div_re (
    .clk      (clk),
    .r_init   (r0_re),
    .divisor  (dv3),
    .low_bits (bits_re),
    .quotient (q_re),
    .rem_nz   (rnz_re)
  );

  cau_div_chain u_div_im (
    .clk      (clk),
    .r_init   (r0_im),
    .divisor  (dv3),
    .low_bits (bits_im),
    .quotient (q_im),
    .rem_nz   (rnz_im)
  );

  cau_root_chain u_mag (
    .clk      (clk),
    .radicand (x3),
    .root     (m)
  );

  side_t sd1 [STEPS];
  always_ff @(posedge clk) begin
    sd1[0] <= side3;
    for (int k = 1; k < STEPS; k++) begin
      sd1[k] <= sd1[k-1];
    end
  end

  // Stage after the first chains: format quotients and the magnitude, and
  // build the half-root radicands (|a| + a_re) and (|a| - a_re), both
  // nonnegative because the floored magnitude is never below |a_re|.
  side_t       s1e, side36, side36_next;
  logic [32:0] dq_re, dq_im;
  logic [63:0] m_ext, ar_ext, xa_next, xb_next, xa, xb;

  assign s1e    = sd1[STEPS-1];
  assign dq_re  = div_fmt(s1e.neg_re, s1e.big_re, s1e.dzero, s1e.nz_re, q_re, rnz_re);
  assign dq_im  = div_fmt(s1e.neg_im, s1e.big_im, s1e.dzero, s1e.nz_im, q_im, rnz_im);
  assign m_ext  = {32'd0, m};
  assign ar_ext = {{32{s1e.ar[31]}}, s1e.ar};

  always_comb begin
    side36_next = s1e;
    xa_next     = (m_ext + ar_ext) << (FRAC_BITS - 1);
    xb_next     = (m_ext - ar_ext) << (FRAC_BITS - 1);
    case (s1e.op)
      OP_DIV, OP_RDIV: begin
        side36_next.re  = dq_re[31:0];
        side36_next.im  = dq_im[31:0];
        side36_next.dz  = s1e.dzero;
        side36_next.sat = dq_re[32] | dq_im[32];
      end
      OP_MAG: begin
        side36_next.re  = m[31] ? Q_MAX : m;
        side36_next.sat = m[31];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    side36 <= side36_next;
    xa     <= xa_next;
    xb     <= xb_next;
  end

  // Second chain section: the two half roots of the principal square root.
  logic [31:0] ra, rb;

  cau_root_chain u_root_re (
    .clk      (clk),
    .radicand (xa),
    .root     (ra)
  );

  cau_root_chain u_root_im (
    .clk      (clk),
    .radicand (xb),
    .root     (rb)
  );

  side_t sd2 [STEPS];
  always_ff @(posedge clk) begin
    sd2[0] <= side36;
    for (int k = 1; k < STEPS; k++) begin
      sd2[k] <= sd2[k-1];
    end
  end

  // Output register. The imaginary root takes the sign of a_im.
  side_t s2e;
  out_t  result_next;

  assign s2e = sd2[STEPS-1];

  always_comb begin
    result_next.result_re      = s2e.re;
    result_next.result_im      = s2e.im;
    result_next.is_equal       = s2e.eq;
    result_next.divide_by_zero = s2e.dz;
    result_next.saturated      = s2e.sat;
    if (s2e.op == OP_SQRT) begin
      result_next.result_re = ra;
      result_next.result_im = s2e.ai_neg ? (~rb + 32'd1) : rb;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

@@ rtl/core/cau_div_cell.sv @@
`timescale 1ns / 1ps

module cau_div_cell (
  input  logic        clk,
  input  logic [63:0] r_in,
  input  logic [63:0] d_in,
  input  logic [31:0] bits_in,
  input  logic [31:0] q_in,
  output logic [63:0] r_out,
  output logic [63:0] d_out,
  output logic [31:0] bits_out,
  output logic [31:0] q_out
);

  logic [64:0] t;
  logic [64:0] dd;
  logic [64:0] diff;
  logic        ge;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  assign t    = {r_in, bits_in[31]};
  assign dd   = {1'b0, d_in};
  assign diff = t - dd;
  assign ge   = (t >= dd);

  always_ff @(posedge clk) begin
    r_out    <= ge ? diff[63:0] : t[63:0];
    d_out    <= d_in;
    bits_out <= {bits_in[30:0], 1'b0};
    q_out    <= {q_in[30:0], ge};
  end

endmodule

@@ rtl/core/cau_root_cell.sv @@
`timescale 1ns / 1ps

module cau_root_cell (
  input  logic        clk,
  input  logic [63:0] x_in,
  input  logic [33:0] r_in,
  input  logic [31:0] q_in,
  output logic [63:0] x_out,
  output logic [33:0] r_out,
  output logic [31:0] q_out
);

  logic [35:0] rs;
  logic [35:0] t;
  logic [35:0] diff;
  logic        ge;

  // One digit of the square root: the trial value is 4q + 1.
  assign rs   = {r_in, x_in[63:62]};
  assign t    = {2'b00, q_in, 2'b01};
  assign diff = rs - t;
  assign ge   = (rs >= t);

  always_ff @(posedge clk) begin
    x_out <= {x_in[61:0], 2'b00};
    r_out <= ge ? diff[33:0] : rs[33:0];
    q_out <= {q_in[30:0], ge};
  end

endmodule

@@ rtl/core/cau_div_chain.sv @@
`timescale 1ns / 1ps

module cau_div_chain (
  input  logic        clk,
  input  logic [63:0] r_init,
  input  logic [63:0] divisor,
  input  logic [31:0] low_bits,
  output logic [31:0] quotient,
  output logic        rem_nz
);

  import cau_pkg::*;

  logic [63:0] r_s    [STEPS+1];
  logic [63:0] d_s    [STEPS+1];
  logic [31:0] bits_s [STEPS+1];
  logic [31:0] q_s    [STEPS+1];

  assign r_s[0]    = r_init;
  assign d_s[0]    = divisor;
  assign bits_s[0] = low_bits;
  assign q_s[0]    = '0;

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    cau_div_cell u_cell (
      .clk      (clk),
      .r_in     (r_s[k]),
      .d_in     (d_s[k]),
      .bits_in  (bits_s[k]),
      .q_in     (q_s[k]),
      .r_out    (r_s[k+1]),
      .d_out    (d_s[k+1]),
      .bits_out (bits_s[k+1]),
      .q_out    (q_s[k+1])
    );
  end

  assign quotient = q_s[STEPS];
  assign rem_nz   = |r_s[STEPS];

endmodule

@@ rtl/core/cau_root_chain.sv @@
`timescale 1ns / 1ps

module cau_root_chain (
  input  logic        clk,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  import cau_pkg::*;

  logic [63:0] x_s [STEPS+1];
  logic [33:0] r_s [STEPS+1];
  logic [31:0] q_s [STEPS+1];

  assign x_s[0] = radicand;
  assign r_s[0] = '0;
  assign q_s[0] = '0;

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    cau_root_cell u_cell (
      .clk   (clk),
      .x_in  (x_s[k]),
      .r_in  (r_s[k]),
      .q_in  (q_s[k]),
      .x_out (x_s[k+1]),
      .r_out (r_s[k+1]),
      .q_out (q_s[k+1])
    );
  end

  assign root = q_s[STEPS];

endmodule
